// ----- hw/rtl/ccsb_pkg.sv -----
// Shared types and constants for the constant color span blend.
`default_nettype none

package ccsb_pkg;

  // Pixel and channel geometry
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned BYTES_PER_PIXEL = 4;
  localparam int unsigned PIXEL_W         = BYTE_W * BYTES_PER_PIXEL;
  localparam int unsigned PIXELS_PER_WORD = 2;

  // Blend arithmetic
  localparam int unsigned PROD_W      = 2 * BYTE_W;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
  localparam logic [PROD_W-1:0] ROUND_BIAS = 16'd128;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = PIXEL_W;
  localparam int unsigned APOS_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_COLOR     = 2'd0,
    REG_FILL_ALPHA     = 2'd1,
    REG_ALPHA_POSITION = 2'd2,
    REG_BLEND_MODE     = 2'd3
  } ccsb_reg_e;

  typedef enum logic {
    MODE_SOLID = 1'b0,
    MODE_OVER  = 1'b1
  } ccsb_mode_e;

  // Reset values of the configuration registers
  localparam logic [PIXEL_W-1:0] FILL_COLOR_RST = 32'h0000_0000;
  localparam logic [BYTE_W-1:0]  FILL_ALPHA_RST = 8'hFF;
  localparam logic [APOS_W-1:0]  ALPHA_POS_RST  = 2'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/ccsb_in_if.sv -----
// Input stream channel: destination word and pixel count.
`default_nettype none

interface ccsb_in_if #(
  parameter int unsigned WordW = ccsb_pkg::PIXEL_W * ccsb_pkg::PIXELS_PER_WORD,
  parameter int unsigned CntW  = $clog2(ccsb_pkg::PIXELS_PER_WORD + 1)
);
  logic             valid;
  logic             ready;
  logic [WordW-1:0] dest_word;
  logic [CntW-1:0]  pixel_count;

  modport source (output valid, output dest_word, output pixel_count, input ready);
  modport sink   (input valid, input dest_word, input pixel_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ccsb_out_if.sv -----
// Output stream channel: blended result word.
`default_nettype none

interface ccsb_out_if #(
  parameter int unsigned WordW = ccsb_pkg::PIXEL_W * ccsb_pkg::PIXELS_PER_WORD
);
  logic             valid;
  logic             ready;
  logic [WordW-1:0] result_word;

  modport source (output valid, output result_word, input ready);
  modport sink   (input valid, input result_word, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/constant_color_span_blend.sv -----
// Top level of the constant color span blend pipeline.
`default_nettype none

// Applies one configured constant color to up to PIXELS_PER_WORD 32-bit pixels of each
// input word, either as a solid store of all four bytes or as a source-over blend that
// rounds (s*a + d*(255-a))/255 per byte and keeps the destination alpha byte. The block
// takes one word every cycle, unless the output stalls, through three register stages: an
// input stage, a stage that holds the per-byte products and a final output register. A
// result passes from the input stage through the product stage into the output register
// before it is presented. All stages advance together; ready drops only while the output
// register holds a result that has not been taken. Pixels at or above the pixel count pass
// through unchanged. Configuration is written through the plain write port; the user must
// write it only while the pipeline is empty, as the block itself does not enforce this.
module constant_color_span_blend #(
  parameter int unsigned PIXELS_PER_WORD = ccsb_pkg::PIXELS_PER_WORD
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ccsb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ccsb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ccsb_in_if.sink                              dest_i,
  ccsb_out_if.source                           res_o
);

  localparam int unsigned WordW = ccsb_pkg::PIXEL_W * PIXELS_PER_WORD;
  localparam int unsigned CntW  = $clog2(PIXELS_PER_WORD + 1);
  localparam int unsigned BW    = ccsb_pkg::BYTE_W;
  localparam int unsigned NB    = ccsb_pkg::BYTES_PER_PIXEL;
  localparam int unsigned PW    = ccsb_pkg::PIXEL_W;
  localparam int unsigned TW    = ccsb_pkg::PROD_W;

  typedef logic [TW-1:0] prod_t;

  // Configuration registers
  logic [PW-1:0]                  fill_color_q;
  logic [BW-1:0]                  fill_alpha_q;
  logic [ccsb_pkg::APOS_W-1:0]    alpha_pos_q;
  ccsb_pkg::ccsb_mode_e           blend_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_color_q <= ccsb_pkg::FILL_COLOR_RST;
      fill_alpha_q <= ccsb_pkg::FILL_ALPHA_RST;
      alpha_pos_q  <= ccsb_pkg::ALPHA_POS_RST;
      blend_mode_q <= ccsb_pkg::MODE_SOLID;
    end else if (cfg_we_i) begin
      case (ccsb_pkg::ccsb_reg_e'(cfg_idx_i))
        ccsb_pkg::REG_FILL_COLOR:     fill_color_q <= cfg_data_i[PW-1:0];
        ccsb_pkg::REG_FILL_ALPHA:     fill_alpha_q <= cfg_data_i[BW-1:0];
        ccsb_pkg::REG_ALPHA_POSITION: alpha_pos_q  <= cfg_data_i[ccsb_pkg::APOS_W-1:0];
        ccsb_pkg::REG_BLEND_MODE:     blend_mode_q <= ccsb_pkg::ccsb_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves when the output register is free or taken
  logic adv;
  logic in_xfer;
  logic s1_vld_q, s2_vld_q, out_vld_q;

  assign adv          = !out_vld_q || res_o.ready;
  assign dest_i.ready = adv;
  assign in_xfer      = dest_i.valid && adv;
  assign res_o.valid  = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_xfer;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // Stage 1: register the incoming transfer
  logic [WordW-1:0] s1_word_q;
  logic [CntW-1:0]  s1_cnt_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_word_q <= dest_i.dest_word;
      s1_cnt_q  <= dest_i.pixel_count;
    end
  end

  // Stage 2: per-byte products, bias added; pixel valid flags from the count
  logic [BW-1:0]         inv_alpha;
  prod_t                 src_prod [NB];
  prod_t                 t_d      [PIXELS_PER_WORD][NB];
  prod_t                 t_q      [PIXELS_PER_WORD][NB];
  logic [PIXELS_PER_WORD-1:0] pv_d, s2_pv_q;
  logic [WordW-1:0]      s2_word_q;

  assign inv_alpha = ccsb_pkg::BYTE_MAX - fill_alpha_q;

  for (genvar k = 0; k < NB; k++) begin : g_src
    assign src_prod[k] = prod_t'(fill_color_q[k*BW +: BW]) * prod_t'(fill_alpha_q);
  end

  for (genvar p = 0; p < PIXELS_PER_WORD; p++) begin : g_s2
    assign pv_d[p] = s1_cnt_q > CntW'(p);
    for (genvar k = 0; k < NB; k++) begin : g_byte
      assign t_d[p][k] = src_prod[k]
                       + prod_t'(s1_word_q[p*PW + k*BW +: BW]) * prod_t'(inv_alpha)
                       + ccsb_pkg::ROUND_BIAS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q       <= t_d;
      s2_pv_q   <= pv_d;
      s2_word_q <= s1_word_q;
    end
  end

  // Stage 3: divide by 255, pick per mode and pixel, register the result
  logic [WordW-1:0] res_d, res_q;

  for (genvar p = 0; p < PIXELS_PER_WORD; p++) begin : g_s3
    logic [PW-1:0] over_px;
    for (genvar k = 0; k < NB; k++) begin : g_byte
      logic [TW:0] fold;
      assign fold = {1'b0, t_q[p][k]} + {1'b0, (t_q[p][k] >> BW)};
      assign over_px[k*BW +: BW] = (alpha_pos_q == ccsb_pkg::APOS_W'(k))
                                 ? s2_word_q[p*PW + k*BW +: BW]
                                 : fold[TW-1:BW];
    end
    always_comb begin
      if (!s2_pv_q[p]) begin
        res_d[p*PW +: PW] = s2_word_q[p*PW +: PW];
      end else if (blend_mode_q == ccsb_pkg::MODE_SOLID) begin
        res_d[p*PW +: PW] = fill_color_q;
      end else begin
        res_d[p*PW +: PW] = over_px;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.result_word = res_q;

`ifndef SYNTHESIS
  // A valid product stage moves into the output register when the pipe advances
  a_s2_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && adv |=> out_vld_q)
    else $error("stage 2 item lost on advance");

  // A stalled product stage keeps its item and data
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && !adv |=> s2_vld_q && $stable(s2_word_q) && $stable(s2_pv_q))
    else $error("stage 2 changed during stall");

  // A taken result with nothing behind it empties the output register
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_o.ready && !s2_vld_q |=> !out_vld_q)
    else $error("result repeated after transfer");
`endif

endmodule

`default_nettype wire
